FILE: rtl/swm_pkg.sv
// Shared types and constants of the sliding-window median filter.
package swm_pkg;

    // Widths fixed by the sample and result formats.
    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;

    // Configuration port layout.
    localparam int CFG_W  = 6;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Register index, taken from paddr[2].
    localparam logic REG_WINDOW_SIZE = 1'b0;

    // Window size after reset.
    localparam logic [CFG_W-1:0] WINDOW_RESET = 6'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [MEDIAN_W-1:0] median_t;

    // Value and compare flag passed between neighboring cells.
    typedef struct packed {
        sample_t value;
        logic    gt;
    } link_t;

    // Step controls broadcast to every cell.
    typedef struct packed {
        logic en;
        logic remove;
    } cell_ctl_t;

endpackage

FILE: rtl/sliding_window_median.sv
// Top level of the sliding-window median filter: control, arrival ring and register port.
//
//   Channel   Signals                               Direction  Payload
//   input     in_valid, in_stall                    in         sample, new_sequence
//   output    out_valid, out_stall                  out        median_doubled
//   config    psel, penable, pwrite, paddr, pwdata  in         window_size at byte 0
//
// A sample passes the idle and update steps while the window fills, and the
// pick step too once a median is produced: idle reads the evicted sample from
// the arrival ring, update lets the cell row update, pick adds the two middle
// cells into the output register. The ring's single read port sets the first step.
// Reset empties the window and sets window_size to 3; no clearing pass is needed.
// A stalled result holds the next median back but not the next sample.
module sliding_window_median
#(
    parameter int MAX_WINDOW = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  swm_pkg::sample_t                  sample,
    input  logic                              new_sequence,
    output logic                              out_valid,
    input  logic                              out_stall,
    output swm_pkg::median_t                  median_doubled,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swm_pkg::ADDR_W-1:0]        paddr,
    input  logic [swm_pkg::DATA_W-1:0]        pwdata,
    output logic [swm_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_PICK   = 2'd2;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [swm_pkg::CFG_W-1:0]   window_size_reg;
    logic [CW-1:0]               fill_reg;
    logic [CW-1:0]               fill_next;
    logic [AW-1:0]               ptr_reg;
    logic [AW-1:0]               ptr_next;
    swm_pkg::sample_t            sample_reg;
    swm_pkg::sample_t            oldest_reg;
    swm_pkg::median_t            median_reg;
    logic                        out_valid_reg;

    swm_pkg::sample_t            ring_mem [MAX_WINDOW];

    logic                        accept;
    logic                        cfg_write;
    logic [31:0]                 cfg_wide;
    logic [CW-1:0]               w_eff;
    logic                        restart;
    logic [CW-1:0]               fill_adj;
    logic [AW-1:0]               ptr_adj;
    logic                        replace;
    logic [CW-1:0]               ptr_inc;
    logic [CW-1:0]               kept_count;
    logic [AW-1:0]               ring_waddr;
    logic                        ring_we;
    logic [AW-1:0]               mid_hi;
    logic [AW-1:0]               mid_lo;
    swm_pkg::cell_ctl_t          ctl;
    swm_pkg::sample_t            lo_value;
    swm_pkg::sample_t            hi_value;
    logic                        out_free;

    // Handshakes.
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    // Register read-back.
    assign prdata = (paddr[2] == swm_pkg::REG_WINDOW_SIZE) ?
                    swm_pkg::DATA_W'(window_size_reg) : '0;

    // Effective window: zero acts as one, large values clip to the row length.
    assign cfg_wide = 32'(window_size_reg);
    always_comb
    begin
        if (cfg_wide == 32'd0)
        begin
            w_eff = CW'(1);
        end
        else if (cfg_wide > 32'(MAX_WINDOW))
        begin
            w_eff = CW'(MAX_WINDOW);
        end
        else
        begin
            w_eff = CW'(cfg_wide);
        end
    end

    // Window bookkeeping as seen by a newly accepted sample.
    assign restart  = new_sequence || (fill_reg > w_eff);
    assign fill_adj = restart ? '0 : fill_reg;
    assign ptr_adj  = (restart || (CW'(ptr_reg) >= w_eff)) ? '0 : ptr_reg;

    // Update step: replace the oldest sample once the window is full.
    assign replace    = (fill_reg == w_eff);
    assign ptr_inc    = CW'(ptr_reg) + CW'(1);
    assign kept_count = replace ? (w_eff - CW'(1)) : fill_reg;
    assign ring_waddr = replace ? ptr_reg : AW'(fill_reg);
    assign ring_we    = (state_reg == ST_UPDATE);
    assign ctl        = '{en: ring_we, remove: replace};

    always_comb
    begin
        fill_next = fill_reg;
        ptr_next  = ptr_reg;
        if (replace)
        begin
            ptr_next = (ptr_inc >= w_eff) ? '0 : AW'(ptr_inc);
        end
        else
        begin
            fill_next = fill_reg + CW'(1);
        end
    end

    // Middle positions of the window.
    assign mid_hi = AW'(w_eff >> 1);
    assign mid_lo = w_eff[0] ? mid_hi : (mid_hi - AW'(1));

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = (fill_next == w_eff) ? ST_PICK : ST_IDLE;
            end
            ST_PICK:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            window_size_reg <= swm_pkg::WINDOW_RESET;
            fill_reg        <= '0;
            ptr_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write && (paddr[2] == swm_pkg::REG_WINDOW_SIZE))
            begin
                window_size_reg <= pwdata[swm_pkg::CFG_W-1:0];
                fill_reg        <= '0;
                ptr_reg         <= '0;
            end
            else if (accept)
            begin
                fill_reg <= fill_adj;
                ptr_reg  <= ptr_adj;
            end
            else if (state_reg == ST_UPDATE)
            begin
                fill_reg <= fill_next;
                ptr_reg  <= ptr_next;
            end
            if ((state_reg == ST_PICK) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Sample and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
        end
        if ((state_reg == ST_PICK) && out_free)
        begin
            median_reg <= swm_pkg::median_t'(lo_value) + swm_pkg::median_t'(hi_value);
        end
    end

    // Arrival ring: written in the update step, read when a sample is accepted.
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= sample_reg;
        end
        if (accept)
        begin
            oldest_reg <= ring_mem[ptr_adj];
        end
    end

    swm_sorter
    #(
        .MAX_WINDOW (MAX_WINDOW),
        .CW         (CW),
        .AW         (AW)
    )
    u_sorter
    (
        .clk        (clk),
        .ctl        (ctl),
        .new_value  (sample_reg),
        .old_value  (oldest_reg),
        .kept_count (kept_count),
        .mid_lo     (mid_lo),
        .mid_hi     (mid_hi),
        .lo_value   (lo_value),
        .hi_value   (hi_value)
    );

    assign out_valid      = out_valid_reg;
    assign median_doubled = median_reg;

    // An accepted request always goes to the update step next.
    a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_UPDATE))
        else $error("accepted request did not enter the update step");

    // The ring pointer stays inside the window during an update.
    a_ptr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> (CW'(ptr_reg) < w_eff))
        else $error("oldest pointer outside the window");

    // The fill count never passes the row length.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(MAX_WINDOW))
        else $error("fill count beyond the row length");

    // A median with a free output register is presented in the next cycle.
    a_pick_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_PICK) && out_free) |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("median was not presented");

endmodule

FILE: rtl/swm_cell.sv
// One cell of the sorted window: holds one value and updates it from its neighbors.
module swm_cell
(
    input  logic                clk,
    input  swm_pkg::cell_ctl_t  ctl,
    input  swm_pkg::sample_t    new_value,
    input  swm_pkg::sample_t    old_value,
    input  logic                live,
    input  swm_pkg::link_t      from_left,
    input  swm_pkg::link_t      from_right,
    output swm_pkg::link_t      to_left,
    output swm_pkg::link_t      to_right,
    output swm_pkg::sample_t    value
);

    swm_pkg::sample_t value_reg;
    swm_pkg::sample_t value_next;
    swm_pkg::sample_t shifted;
    logic             gt_new;
    logic             at_or_after_old;
    logic             shifted_gt;

    // Local compares against the incoming sample and the evicted sample.
    assign gt_new          = (value_reg > new_value);
    assign at_or_after_old = ctl.remove && (value_reg >= old_value);

    // Close the gap left by the evicted value: cells from it onward take the right value.
    assign shifted    = at_or_after_old ? from_right.value : value_reg;
    assign shifted_gt = !live || (at_or_after_old ? from_right.gt : gt_new);

    // Open a slot for the new sample: larger values move one cell to the right.
    always_comb
    begin
        if (!shifted_gt)
        begin
            value_next = shifted;
        end
        else if (!from_left.gt)
        begin
            value_next = new_value;
        end
        else
        begin
            value_next = from_left.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            value_reg <= value_next;
        end
    end

    assign to_left  = '{value: value_reg, gt: gt_new};
    assign to_right = '{value: shifted, gt: shifted_gt};
    assign value    = value_reg;

endmodule

FILE: rtl/swm_sorter.sv
// Row of sorting cells and the selection of the two middle values.
module swm_sorter
#(
    parameter int MAX_WINDOW = 32,
    parameter int CW         = 6,
    parameter int AW         = 5
)
(
    input  logic                clk,
    input  swm_pkg::cell_ctl_t  ctl,
    input  swm_pkg::sample_t    new_value,
    input  swm_pkg::sample_t    old_value,
    input  logic [CW-1:0]       kept_count,
    input  logic [AW-1:0]       mid_lo,
    input  logic [AW-1:0]       mid_hi,
    output swm_pkg::sample_t    lo_value,
    output swm_pkg::sample_t    hi_value
);

    swm_pkg::link_t   left_link  [MAX_WINDOW];
    swm_pkg::link_t   right_link [MAX_WINDOW];
    swm_pkg::sample_t cell_value [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] live;

    // Each cell sees its neighbors; the row ends act as minus and plus infinity.
    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        swm_pkg::link_t from_left;
        swm_pkg::link_t from_right;

        assign live[i] = (CW'(i) < kept_count);

        if (i == 0)
        begin : g_first
            assign from_left = '{value: '0, gt: 1'b0};
        end
        else
        begin : g_inner_left
            assign from_left = right_link[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_last
            assign from_right = '{value: '0, gt: 1'b1};
        end
        else
        begin : g_inner_right
            assign from_right = left_link[i+1];
        end

        swm_cell u_cell
        (
            .clk        (clk),
            .ctl        (ctl),
            .new_value  (new_value),
            .old_value  (old_value),
            .live       (live[i]),
            .from_left  (from_left),
            .from_right (from_right),
            .to_left    (left_link[i]),
            .to_right   (right_link[i]),
            .value      (cell_value[i])
        );
    end

    // Pick the two middle cells with an AND-OR tree over the row.
    always_comb
    begin
        lo_value = '0;
        hi_value = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if (AW'(i) == mid_lo)
            begin
                lo_value = lo_value | cell_value[i];
            end
            if (AW'(i) == mid_hi)
            begin
                hi_value = hi_value | cell_value[i];
            end
        end
    end

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench of the sliding-window median filter.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIN       = 32;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 130;
    localparam logic [swm_pkg::ADDR_W-1:0] WINDOW_ADDR = {swm_pkg::REG_WINDOW_SIZE, 2'b00};
    localparam swm_pkg::sample_t S_MAX = 32'sh7FFF_FFFF;
    localparam swm_pkg::sample_t S_MIN = 32'sh8000_0000;

    // One input request and one median awaiting its result.
    typedef struct packed {
        swm_pkg::sample_t value;
        logic             fresh;
    } request_t;

    typedef struct {
        swm_pkg::median_t value;
        int               item_no;
    } median_due_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    swm_pkg::sample_t sample = '0;
    logic new_sequence = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    swm_pkg::median_t median_doubled;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [swm_pkg::ADDR_W-1:0] paddr = '0;
    logic [swm_pkg::DATA_W-1:0] pwdata = '0;
    logic [swm_pkg::DATA_W-1:0] prdata;
    logic pready;

    request_t    pending[$];
    median_due_t medians_due[$];

    // Window state kept by the predictor.
    logic [swm_pkg::CFG_W-1:0] win_reg = swm_pkg::WINDOW_RESET;
    swm_pkg::sample_t ring [MAX_WIN];
    swm_pkg::sample_t sorted_q[$];
    int held = 0;
    int oldest = 0;

    int errors = 0;
    int samples_taken = 0;
    int medians_checked = 0;
    int restarts = 0;
    int windows_written = 0;
    int quiet_cycles = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit steady = 1'b0;

    sliding_window_median #(
        .MAX_WINDOW(MAX_WIN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample(sample),
        .new_sequence(new_sequence),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .median_doubled(median_doubled),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        errors++;
    endtask

    // Advance the window by one sample and queue the median it yields, if any.
    task automatic take_sample(input swm_pkg::sample_t s, input logic fresh);
        int w;
        int idx;
        swm_pkg::sample_t gone;
        swm_pkg::median_t lo;
        swm_pkg::median_t hi;
        median_due_t due;
        w = (win_reg == 0) ? 1 : ((win_reg > MAX_WIN) ? MAX_WIN : int'(win_reg));
        samples_taken++;
        if (fresh)
        begin
            held = 0;
            oldest = 0;
            sorted_q.delete();
            restarts++;
        end
        if (held < w)
        begin
            ring[held] = s;
            held++;
        end
        else
        begin
            // Drop one copy of the oldest value before the new one goes in.
            gone = ring[oldest];
            for (idx = 0; idx < sorted_q.size(); idx++)
            begin
                if (sorted_q[idx] == gone)
                begin
                    sorted_q.delete(idx);
                    break;
                end
            end
            ring[oldest] = s;
            oldest = (oldest + 1 >= w) ? 0 : oldest + 1;
        end
        idx = sorted_q.size();
        while (idx > 0 && sorted_q[idx - 1] > s)
            idx--;
        sorted_q.insert(idx, s);
        if (held == w)
        begin
            lo = sorted_q[(w - 1) / 2];
            hi = sorted_q[w / 2];
            due.value = lo + hi;
            due.item_no = samples_taken;
            medians_due.insert(medians_due.size(), due);
        end
    endtask

    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Samples mix full-range values, a narrow band that forces duplicates, and the extremes.
    function automatic swm_pkg::sample_t pick_sample();
        int unsigned mode;
        mode = $urandom_range(0, 9);
        if (mode < 4)
            return swm_pkg::sample_t'($urandom);
        if (mode < 7)
            return swm_pkg::sample_t'(int'($urandom_range(0, 16)) - 8);
        if (mode == 7)
        begin
            case ($urandom_range(0, 3))
                0: return S_MAX;
                1: return S_MIN;
                2: return swm_pkg::sample_t'(0);
                default: return swm_pkg::sample_t'(-1);
            endcase
        end
        if (mode == 8)
            return swm_pkg::sample_t'(S_MAX - swm_pkg::sample_t'($urandom_range(0, 3)));
        return swm_pkg::sample_t'(S_MIN + swm_pkg::sample_t'($urandom_range(0, 3)));
    endfunction

    task automatic queue_request(input swm_pkg::sample_t s, input logic fresh);
        request_t r;
        r.value = s;
        r.fresh = fresh;
        pending.insert(pending.size(), r);
    endtask

    // Wait until every request has gone in and every median has come out, then let the pipe settle.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending.size() != 0 || in_valid || medians_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write followed by a read back of the same register.
    task automatic write_window(input logic [swm_pkg::CFG_W-1:0] val);
        logic [swm_pkg::DATA_W-1:0] junk;
        logic [swm_pkg::DATA_W-1:0] rd;
        junk = $urandom;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= WINDOW_ADDR;
        pwdata <= {junk[swm_pkg::DATA_W-1:swm_pkg::CFG_W], val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        win_reg = val;
        held = 0;
        oldest = 0;
        sorted_q.delete();
        windows_written++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== {{(swm_pkg::DATA_W - swm_pkg::CFG_W){1'b0}}, val})
            flag_error($sformatf("window_size read back %0h, wrote %0h", rd, val));
    endtask

    // Request driver: holds the payload while stalled, inserts random gaps between requests.
    always @(posedge clk or negedge rst_n)
    begin : send
        request_t next;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample <= '0;
            new_sequence <= 1'b0;
            gap_left <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending.size() != 0)
            begin
                next = pending.pop_front();
                in_valid <= 1'b1;
                sample <= next.value;
                new_sequence <= next.fresh;
                gap_left <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result back-pressure: mostly short stalls, a few long ones, none in steady phases.
    always @(posedge clk or negedge rst_n)
    begin : backpressure
        int unsigned roll;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (steady)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 65)
            begin
                out_stall <= 1'b0;
                stall_left <= $urandom_range(0, 6);
            end
            else if (roll < 95)
            begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(15, 40);
            end
        end
    end

    // Monitor: checks each accepted median, then predicts from each accepted request.
    always @(posedge clk)
    begin : watch
        median_due_t due;
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                medians_checked++;
                if (medians_due.size() == 0)
                begin
                    flag_error($sformatf("median %0d with none outstanding", median_doubled));
                end
                else
                begin
                    due = medians_due.pop_front();
                    if (median_doubled !== due.value)
                        flag_error($sformatf("sample %0d: median_doubled %0d, predicted %0d",
                                             due.item_no, median_doubled, due.value));
                end
            end
            if (in_valid && !in_stall)
                take_sample(sample, new_sequence);
            if ((out_valid && !out_stall) || (in_valid && !in_stall) || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial
    begin
        wait (rst_n);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Timeout after %0d idle cycles", quiet_cycles);
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus: directed extremes first, then random phases over many window sizes.
    initial
    begin
        logic [swm_pkg::CFG_W-1:0] win_plan [12];
        int p;
        int n;
        win_plan = '{6'd5, 6'd32, 6'd4, 6'd1, 6'd0, 6'd63, 6'd33, 6'd7, 6'd16, 6'd2, 6'd3,
                     6'd0};
        win_plan[11] = $urandom_range(0, 63);

        // Reset window of three: extremes, a mixed-sign window and a restart mid-stream.
        queue_request(S_MAX, 1'b0);
        queue_request(S_MIN, 1'b0);
        queue_request(swm_pkg::sample_t'(0), 1'b0);
        queue_request(swm_pkg::sample_t'(-1), 1'b0);
        queue_request(S_MAX, 1'b0);
        queue_request(S_MAX, 1'b0);
        queue_request(S_MAX, 1'b0);
        queue_request(S_MIN, 1'b1);
        queue_request(S_MIN, 1'b0);
        queue_request(S_MIN, 1'b0);
        queue_request(swm_pkg::sample_t'(1), 1'b0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        // Even window: the two middle values add, so the half-step shows up exactly.
        write_window(6'd2);
        queue_request(S_MAX, 1'b1);
        queue_request(S_MAX, 1'b0);
        queue_request(S_MIN, 1'b0);
        queue_request(S_MIN, 1'b0);
        queue_request(swm_pkg::sample_t'(5), 1'b0);
        queue_request(swm_pkg::sample_t'(5), 1'b0);

        for (p = 0; p < 12; p++)
        begin
            wait_drained();
            steady = (p % 4 == 3);
            write_window(win_plan[p]);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Halfway through one phase the sender holds off until all medians are back.
                if (p == 2 && n == PHASE_ITEMS / 2)
                    wait_drained();
                queue_request(pick_sample(), ($urandom_range(0, 99) < 3));
            end
        end

        wait_drained();
        $display("Covered %0d samples and %0d medians over %0d window writes, %0d restarts.",
                 samples_taken, medians_checked, windows_written, restarts);
        $display("Windows ranged from 1 to %0d, including out-of-range settings.", MAX_WIN);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sliding_window_median.f
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_sorter.sv
rtl/sliding_window_median.sv
bench/tb_top.sv
